/* rtl/core/afrb_pkg.sv */
package afrb_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned CC_W     = 4;
  localparam logic [CC_W-1:0] CC_RESET = 4'd2;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD1  = 3'b010,
    ST_RD2  = 3'b100
  } state_e;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       frame_valid;
  } out_t;

endpackage

/* rtl/core/afrb_ram.sv */
module afrb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/afrb_ctrl.sv */
module afrb_ctrl import afrb_pkg::*; #(
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned FW = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CC_W-1:0]     cc_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_waddr_o,
  output logic [SAMPLE_W-1:0] mem_wdata_o,
  output logic                mem_re_o,
  output logic [AW-1:0]       mem_raddr_o,
  input  logic [SAMPLE_W-1:0] mem_rdata_i
);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] pos,
                                             input logic [CC_W-1:0] n);
    logic [AW:0] s;
    s = {1'b0, pos} + (AW+1)'(n);
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  state_e              state_q, state_d;
  logic [AW-1:0]       rp_q, rp_d;
  logic [AW-1:0]       wp_q, wp_d;
  logic [FW-1:0]       fill_q, fill_d;
  logic                hit_q, hit_d;
  logic [SAMPLE_W-1:0] left_q, left_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;

  logic          accept;
  logic          out_free;
  logic          hit;
  logic [FW-1:0] cc_ext;
  logic [AW-1:0] rp_inc1;
  logic [AW-1:0] rp_incc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cc_ext     = FW'(cc_i);
  assign hit        = (cc_i != '0) && (fill_q >= cc_ext);
  assign rp_inc1    = wrap_add(rp_q, CC_W'(1));
  assign rp_incc    = wrap_add(rp_q, cc_i);

  assign mem_we_o    = accept && (in_data_i.cmd == CMD_PUSH);
  assign mem_waddr_o = wp_q;
  assign mem_wdata_o = in_data_i.sample_in;
  // first word at accept, second word while the first one arrives
  assign mem_re_o    = (accept && (in_data_i.cmd == CMD_READ)) || (state_q == ST_RD1);
  assign mem_raddr_o = (state_q == ST_RD1) ? rp_inc1 : rp_q;

  always_comb begin
    state_d     = state_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    hit_d       = hit_q;
    left_d      = left_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.cmd)
            CMD_PUSH: begin
              // full: drop the oldest word
              if (fill_q == FW'(DEPTH)) begin
                rp_d = rp_inc1;
              end else begin
                fill_d = fill_q + FW'(1);
              end
              wp_d = wrap_add(wp_q, CC_W'(1));
            end
            CMD_READ: begin
              hit_d   = hit;
              state_d = ST_RD1;
            end
            CMD_CLEAR: begin
              rp_d   = '0;
              wp_d   = '0;
              fill_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_RD1: begin
        left_d  = mem_rdata_i;
        state_d = ST_RD2;
      end
      ST_RD2: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          if (hit_q) begin
            out_d.left_sample  = left_q;
            out_d.right_sample = (cc_i == CC_W'(1)) ? left_q : mem_rdata_i;
            out_d.frame_valid  = 1'b1;
            rp_d   = rp_incc;
            fill_d = fill_q - cc_ext;
          end else begin
            out_d.left_sample  = '0;
            out_d.right_sample = '0;
            out_d.frame_valid  = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rp_q        <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q <= left_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  logic [AW+1:0] ptr_sum;
  logic [AW+1:0] ptr_chk;
  assign ptr_sum = (AW+2)'(rp_q) + (AW+2)'(fill_q);
  assign ptr_chk = (ptr_sum >= (AW+2)'(DEPTH)) ? ptr_sum - (AW+2)'(DEPTH) : ptr_sum;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(DEPTH))
    else $error("fill count above depth");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_chk == (AW+2)'(wp_q))
    else $error("read pointer plus fill count does not meet write pointer");

  a_read_consume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD2 && out_free && hit_q)
      |=> (fill_q == $past(fill_q - cc_ext)) && out_valid_q && out_q.frame_valid)
    else $error("frame read did not consume one frame");

endmodule

/* rtl/core/audio_frame_ring_buffer_core.sv */
// channel   direction  handshake                   word
// in        input      in_valid_i / in_stall_o     in_data_i   (cmd, sample_in)
// out       output     out_valid_o / out_stall_i   out_data_o  (left, right, frame_valid)
// cfg       input      cfg_we_i                    cfg_wdata_i (channels per frame)
//
// Push and clear complete at accept; a frame read steps through accept, two sample
// store reads through its single read port, and output load.
// A read result waits in the output register while out_stall_i is high; the
// next word is taken once the read has loaded that register.
// Reset clears pointers, fill count and output valid; channels per frame go to 2.
// The sample store is not cleared; the fill count keeps reads within written words.
module audio_frame_ring_buffer_core import afrb_pkg::*; #(
  parameter int unsigned DEPTH        = 16384,
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CC_W-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_t             in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_t            out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [CC_W-1:0] cc_q, cc_d;

  // saturate the channel count at the supported maximum
  always_comb begin
    cc_d = cc_q;
    if (cfg_we_i) begin
      if ({1'b0, cfg_wdata_i} > (CC_W+1)'(MAX_CHANNELS)) begin
        cc_d = CC_W'(MAX_CHANNELS);
      end else begin
        cc_d = cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= CC_RESET;
    end else begin
      cc_q <= cc_d;
    end
  end

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [SAMPLE_W-1:0] mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [SAMPLE_W-1:0] mem_rdata;

  afrb_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  afrb_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cc_i        (cc_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule

/* tb/sv/tb_audio_frame_ring_buffer_core.sv */
module tb_audio_frame_ring_buffer_core;
  import afrb_pkg::*;

  localparam int unsigned RING_DEPTH       = 16384;
  localparam int unsigned MAX_CHANS        = 8;
  localparam logic [1:0]  CMD_UNUSED       = 2'd3;
  localparam int          SETTLE_CYCLES    = 8;
  localparam int          DRAIN_LIMIT      = 4000;
  localparam int          CYCLE_LIMIT      = 3000000;
  localparam int          MIX_WORDS        = 160;
  localparam int          LONG_HOLD_AT     = 40;
  localparam int          LONG_HOLD_CYCLES = 400;
  localparam int          PRINT_CAP        = 50;

  typedef struct {
    bit              cfg_row;
    logic [CC_W-1:0] cc;
    in_t             w;
    bit              lit;
    out_t            frame;
  } script_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CC_W-1:0] cfg_wdata_i;
  logic            in_valid_i;
  logic            in_stall_o;
  in_t             in_data_i;
  logic            out_valid_o;
  logic            out_stall_i;
  out_t            out_data_o;

  // predicted ring state
  logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  int unsigned         rd_ptr;
  int unsigned         wr_ptr;
  int unsigned         held;
  logic [CC_W-1:0]     chans;

  out_t        frames_due [$];
  script_row_t script [$];

  int  mismatches;
  int  words_in;
  int  frames_out;
  int  frames_full;
  int  cc_writes;
  int  cycles;
  bit  no_idle;
  bit  long_hold_done;

  audio_frame_ring_buffer_core #(
    .DEPTH        (RING_DEPTH),
    .MAX_CHANNELS (MAX_CHANS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frames still due", cycles, frames_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH: %s", msg);
  endtask

  function automatic int draw_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  // Advance the predicted ring by one accepted word; a read always yields a frame.
  function automatic void ring_step(input in_t w, output bit has, output out_t frame);
    has   = 1'b0;
    frame = '0;
    case (w.cmd)
      CMD_PUSH: begin
        if (held >= RING_DEPTH) rd_ptr = (rd_ptr + 1) % RING_DEPTH;
        else held++;
        ring_mem[wr_ptr] = w.sample_in;
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
      end
      CMD_CLEAR: begin
        rd_ptr = 0;
        wr_ptr = 0;
        held   = 0;
      end
      CMD_READ: begin
        has = 1'b1;
        if (chans != 0 && held >= chans) begin
          frame.left_sample  = ring_mem[rd_ptr];
          frame.right_sample = (chans == 1) ? ring_mem[rd_ptr]
                                            : ring_mem[(rd_ptr + 1) % RING_DEPTH];
          frame.frame_valid  = 1'b1;
          rd_ptr = (rd_ptr + chans) % RING_DEPTH;
          held   = held - chans;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_t rand_word(input logic [1:0] c);
    logic [31:0] r;
    in_t w;
    r = $urandom;
    w.cmd       = c;
    w.sample_in = r[SAMPLE_W-1:0];
    return w;
  endfunction

  function automatic script_row_t word_row(input logic [1:0] c, input logic [SAMPLE_W-1:0] s);
    script_row_t row;
    row = '{cfg_row: 1'b0, cc: '0, w: '{cmd: c, sample_in: s}, lit: 1'b0, frame: '0};
    return row;
  endfunction

  // Read row with the frame typed in.
  function automatic script_row_t frame_row(input logic [SAMPLE_W-1:0] l,
                                            input logic [SAMPLE_W-1:0] r, input logic v);
    script_row_t row;
    row       = word_row(CMD_READ, '0);
    row.lit   = 1'b1;
    row.frame = '{left_sample: l, right_sample: r, frame_valid: v};
    return row;
  endfunction

  function automatic script_row_t chan_row(input logic [CC_W-1:0] v);
    script_row_t row;
    row = word_row(CMD_PUSH, '0);
    row.cfg_row = 1'b1;
    row.cc      = v;
    return row;
  endfunction

  task automatic send_word(input in_t w, input bit lit, input out_t lit_frame);
    int   gap;
    bit   has;
    out_t frame;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ring_step(w, has, frame);
    if (has) frames_due.push_back(lit ? lit_frame : frame);
    if (w.cmd != CMD_UNUSED) words_in++;
    @(negedge clk_i);
  endtask

  // Write the per-frame channel setting once all frames are out and the core has settled.
  task automatic set_channels(input logic [CC_W-1:0] v);
    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    chans = (v > MAX_CHANS) ? CC_W'(MAX_CHANS) : v;
    cc_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly whole frames (one push per channel, then a read), plus loose words.
  task automatic run_mix(input int n_words);
    int sent;
    int k;
    int r;
    sent = 0;
    while (sent < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        k = ($urandom_range(0, 4) == 0) ? $urandom_range(0, chans) : chans;
        repeat (k) send_word(rand_word(CMD_PUSH), 1'b0, '0);
        send_word(rand_word(CMD_READ), 1'b0, '0);
        sent += k + 1;
      end else if (r < 80) begin
        send_word(rand_word(CMD_READ), 1'b0, '0);
        sent++;
      end else if (r < 93) begin
        send_word(rand_word(CMD_PUSH), 1'b0, '0);
        sent++;
      end else if (r < 96) begin
        send_word(rand_word(CMD_CLEAR), 1'b0, '0);
        sent++;
      end else begin
        send_word(rand_word(CMD_UNUSED), 1'b0, '0);
      end
    end
  endtask

  initial begin : frame_sink
    int   hold;
    out_t want;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      hold = draw_gap();
      if (!long_hold_done && frames_out >= LONG_HOLD_AT) begin
        hold += LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      frames_out++;
      if (frames_due.size() == 0) begin
        report_mismatch($sformatf("unexpected frame %0d: %h", frames_out, out_data_o));
      end else begin
        want = frames_due.pop_front();
        if (want.frame_valid) frames_full++;
        if (out_data_o.left_sample !== want.left_sample)
          report_mismatch($sformatf("frame %0d left %h, expected %h", frames_out,
                                    out_data_o.left_sample, want.left_sample));
        if (out_data_o.right_sample !== want.right_sample)
          report_mismatch($sformatf("frame %0d right %h, expected %h", frames_out,
                                    out_data_o.right_sample, want.right_sample));
        if (out_data_o.frame_valid !== want.frame_valid)
          report_mismatch($sformatf("frame %0d valid %b, expected %b", frames_out,
                                    out_data_o.frame_valid, want.frame_valid));
      end
    end
  end

  initial begin : stimulus
    logic [CC_W-1:0] phase_cc [8];
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    rd_ptr = 0;
    wr_ptr = 0;
    held   = 0;
    chans  = CC_RESET;

    script.push_back(frame_row(24'h000000, 24'h000000, 1'b0)); // empty after reset
    script.push_back(word_row(CMD_PUSH, 24'h7FFFFF));
    script.push_back(frame_row(24'h000000, 24'h000000, 1'b0)); // one sample, two needed
    script.push_back(word_row(CMD_PUSH, 24'h800000));
    script.push_back(frame_row(24'h7FFFFF, 24'h800000, 1'b1));
    script.push_back(word_row(CMD_UNUSED, 24'hFFFFFF));
    script.push_back(frame_row(24'h000000, 24'h000000, 1'b0));
    script.push_back(word_row(CMD_PUSH, 24'h000001));
    script.push_back(chan_row(4'd1));
    script.push_back(frame_row(24'h000001, 24'h000001, 1'b1)); // mono copies left
    script.push_back(word_row(CMD_PUSH, 24'hFFFFFF));
    script.push_back(chan_row(4'd0));
    script.push_back(frame_row(24'h000000, 24'h000000, 1'b0)); // no channels, no frames
    script.push_back(chan_row(4'd15));                          // saturates to eight
    script.push_back(word_row(CMD_PUSH, 24'h555555));
    script.push_back(word_row(CMD_PUSH, 24'hAAAAAA));
    script.push_back(word_row(CMD_PUSH, 24'h000000));
    script.push_back(word_row(CMD_PUSH, 24'h123456));
    script.push_back(word_row(CMD_PUSH, 24'h7FFFFE));
    script.push_back(word_row(CMD_PUSH, 24'h800001));
    script.push_back(word_row(CMD_PUSH, 24'h3C3C3C));
    script.push_back(word_row(CMD_READ, 24'h000000));
    script.push_back(word_row(CMD_PUSH, 24'hC3C3C3));
    script.push_back(word_row(CMD_CLEAR, 24'h000000));
    script.push_back(frame_row(24'h000000, 24'h000000, 1'b0));

    phase_cc[0] = 4'd1;
    phase_cc[1] = 4'd0;
    phase_cc[2] = 4'd8;
    phase_cc[3] = 4'd15;
    phase_cc[4] = 4'd3;
    phase_cc[5] = 4'd9;
    phase_cc[6] = 4'd7;
    phase_cc[7] = CC_W'($urandom_range(0, 15));

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      if (script[i].cfg_row) set_channels(script[i].cc);
      else send_word(script[i].w, script[i].lit, script[i].frame);
    end

    for (int p = 0; p < 8; p++) begin
      set_channels(phase_cc[p]);
      no_idle = (p % 3 == 2);
      run_mix(MIX_WORDS);
    end

    in_valid_i <= 1'b0;
    no_idle = 1'b0;
    repeat (DRAIN_LIMIT) if (frames_due.size() != 0) @(negedge clk_i);
    if (frames_due.size() != 0)
      report_mismatch($sformatf("%0d frames never arrived", frames_due.size()));
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("sent %0d words over %0d channel-setting writes, incl. mono, skip and saturation",
             words_in, cc_writes);
    $display("checked %0d frames (%0d with data, %0d silent), %0d mismatches",
             frames_out, frames_full, frames_out - frames_full, mismatches);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/afrb_pkg.sv
rtl/core/afrb_ram.sv
rtl/core/afrb_ctrl.sv
rtl/core/audio_frame_ring_buffer_core.sv
tb/sv/tb_audio_frame_ring_buffer_core.sv
